// File: src/overlap_pruning_filter_assert.svh
// assertion macros shared by the checker of the overlap pruning filter
`ifndef OVERLAP_PRUNING_FILTER_ASSERT_SVH
`define OVERLAP_PRUNING_FILTER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define OPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("opf assertion failed");

// next-cycle implication, off while reset is low
`define OPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("opf assertion failed");

// next-cycle implication, also checked across reset
`define OPF_ASSERT_NXT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("opf assertion failed");

`endif

// File: src/opf_pkg.sv
// types and constants of the overlap pruning filter
`timescale 1ns / 1ps

package opf_pkg;

    // width of the coordinate fields at the ports
    localparam int COORD_BITS = 32;

    // output queue depth, a power of two, at least two
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef logic [COORD_BITS-1:0] t_coord;

    // one kept match on its way out
    typedef struct packed {
        t_coord ref_start;
        t_coord ref_end;
        t_coord qry_start;
        t_coord qry_end;
        logic   last;
    } t_result;

    // verdict on one incoming match
    typedef struct packed {
        logic emit_held;  // held match goes out before the new one is held
        logic take_new;   // new match becomes the held match
    } t_decision;

endpackage

// File: src/opf_if.sv
// request and result channel interfaces of the overlap pruning filter
`timescale 1ns / 1ps

interface opf_req_if;
    logic                            valid;
    logic                            ready;
    logic [opf_pkg::COORD_BITS-1:0]  ref_start;
    logic [opf_pkg::COORD_BITS-1:0]  ref_end;
    logic [opf_pkg::COORD_BITS-1:0]  qry_start;
    logic [opf_pkg::COORD_BITS-1:0]  qry_end;
    logic                            list_end;

    modport source (output valid, ref_start, ref_end, qry_start, qry_end, list_end,
                    input ready);
    modport sink   (input valid, ref_start, ref_end, qry_start, qry_end, list_end,
                    output ready);
endinterface

interface opf_res_if;
    logic                            valid;
    logic                            ready;
    logic [opf_pkg::COORD_BITS-1:0]  out_ref_start;
    logic [opf_pkg::COORD_BITS-1:0]  out_ref_end;
    logic [opf_pkg::COORD_BITS-1:0]  out_qry_start;
    logic [opf_pkg::COORD_BITS-1:0]  out_qry_end;
    logic                            out_last;

    modport source (output valid, out_ref_start, out_ref_end, out_qry_start, out_qry_end,
                    out_last, input ready);
    modport sink   (input valid, out_ref_start, out_ref_end, out_qry_start, out_qry_end,
                    out_last, output ready);
endinterface

// File: src/opf_decide.sv
// compares a new match with the held one and decides drop, replace or emit
`timescale 1ns / 1ps

module opf_decide #(
    parameter int CW = 32
) (
    input  logic                           i_held_valid,
    input  logic [CW-1:0]                  i_hrs,
    input  logic [CW-1:0]                  i_hre,
    input  logic [CW-1:0]                  i_hqs,
    input  logic [CW-1:0]                  i_hqe,
    input  logic [CW-1:0]                  i_nrs,
    input  logic [CW-1:0]                  i_nre,
    input  logic [CW-1:0]                  i_nqs,
    input  logic [CW-1:0]                  i_nqe,
    input  logic [opf_pkg::COORD_BITS-1:0] i_min_len,
    output opf_pkg::t_decision             o_dec
);
    import opf_pkg::*;

    logic [CW-1:0] lnr, lnq, lhr, lhq;
    logic          too_short, nested, contains, part_a, part_b;
    logic          r_over_r, r_over_q, l_over_q, trade;
    logic          trade_win;

    // saturating span lengths
    assign lnr = (i_nre >= i_nrs) ? i_nre - i_nrs : '0;
    assign lnq = (i_nqe >= i_nqs) ? i_nqe - i_nqs : '0;
    assign lhr = (i_hre >= i_hrs) ? i_hre - i_hrs : '0;
    assign lhq = (i_hqe >= i_hqs) ? i_hqe - i_hqs : '0;

    assign r_over_r = (i_nrs >= i_hrs) && (i_nrs < i_hre) && (i_nre >= i_hre);
    assign r_over_q = (i_nqs >= i_hqs) && (i_nqs < i_hqe) && (i_nqe >= i_hqe);
    assign l_over_q = (i_nqs <= i_hqs) && (i_hqs < i_nqe) && (i_nqe <= i_hqe);

    assign too_short = (COORD_BITS'(lnq) < i_min_len) && (COORD_BITS'(lnr) < i_min_len);
    assign nested    = (i_nrs >= i_hrs) && (i_nre <= i_hre) &&
                       (i_nqs >= i_hqs) && (i_nqe <= i_hqe);
    assign contains  = (i_hrs >= i_nrs) && (i_hre <= i_nre) &&
                       (i_hqs >= i_nqs) && (i_hqe <= i_nqe);
    assign part_a    = (i_hrs <= i_nrs) && (i_hre >= i_nre) && (r_over_q || l_over_q);
    assign part_b    = (i_hqs <= i_nqs) && (i_hqe >= i_nqe) && r_over_r;
    assign trade     = r_over_r && (r_over_q || l_over_q);

    // length trade-off, first matching rule decides
    always_comb begin
        trade_win = 1'b0;
        priority if ((lnr > lhr) && (lnq > lhq)) begin
            trade_win = 1'b1;
        end else if ((lnr >= lhr) && (lnq <= lhq)) begin
            trade_win = (lnr - lhr) > (lhq - lnq);
        end else if ((lnr <= lhr) && (lnq <= lhq)) begin
            trade_win = 1'b0;
        end else begin
            trade_win = (lhr - lnr) < (lnq - lhq);
        end
    end

    always_comb begin
        o_dec = '0;
        priority if (!i_held_valid) begin
            o_dec.take_new = 1'b1;
        end else if (too_short || nested) begin
            o_dec.take_new = 1'b0;
        end else if (contains) begin
            o_dec.take_new = 1'b1;
        end else if (part_a || part_b) begin
            o_dec.take_new = 1'b0;
        end else if (trade) begin
            o_dec.take_new = trade_win;
        end else begin
            o_dec.emit_held = 1'b1;
            o_dec.take_new  = 1'b1;
        end
    end

endmodule

// File: src/opf_out_fifo.sv
// result queue taking up to two results a cycle and giving one
`timescale 1ns / 1ps

module opf_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_a,
    input  opf_pkg::t_result i_data_a,
    input  logic             i_push_b,
    input  opf_pkg::t_result i_data_b,
    output logic             o_space,
    opf_res_if.source        o_res
);
    import opf_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr, wr_b;
    logic [CNT_W-1:0]   n_count;
    logic               pop;
    t_result            head;

    assign pop     = o_res.valid && o_res.ready;
    assign wr_b    = i_push_a ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
    assign n_wr_ptr = r_wr_ptr + PTR_W'(i_push_a) + PTR_W'(i_push_b);
    assign n_count = r_count + CNT_W'(i_push_a) + CNT_W'(i_push_b) - CNT_W'(pop);

    // room for a full two-result request
    assign o_space = r_count <= CNT_W'(FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr_ptr] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[wr_b] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    assign head                = r_mem[r_rd_ptr];
    assign o_res.valid         = r_count != '0;
    assign o_res.out_ref_start = head.ref_start;
    assign o_res.out_ref_end   = head.ref_end;
    assign o_res.out_qry_start = head.qry_start;
    assign o_res.out_qry_end   = head.qry_end;
    assign o_res.out_last      = head.last;

endmodule

// File: src/overlap_pruning_filter.sv
// top level of the overlap pruning filter
`timescale 1ns / 1ps

// usage
// - i_req carries one match request: reference and query spans plus list_end
// - o_res carries kept matches, out_last set on the flush of a list
// - i_cfg_we / i_cfg_wdata write min_len; write only while the block is idle
// - the held match sits in one register set; each request is judged against it
//   by combinational compares and subtracts and the verdict is applied at the
//   accepting edge
// - a request gives zero, one or two results; they enter a four-entry queue
//   and show on o_res in order, behind any results already queued
// - throughput: one request per cycle while the queue holds two or fewer
//   results; sustained output is one result per cycle while the receiver is
//   ready, so long runs of two-result requests are paced by the queue drain
// - when the receiver stalls the queue fills and i_req.ready drops once
//   fewer than two slots are free; nothing is lost
// - synchronous reset clears the queue, drops the held match and sets
//   min_len to zero; no clearing pass is needed

module overlap_pruning_filter #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [opf_pkg::COORD_BITS-1:0] i_cfg_wdata,
    opf_req_if.sink                        i_req,
    opf_res_if.source                      o_res
);
    import opf_pkg::*;

    // coordinates are masked to COORD_WIDTH bits, at most COORD_BITS; ports are 32 bits wide
    localparam int CW = (COORD_WIDTH < COORD_BITS) ? COORD_WIDTH : COORD_BITS;

    // held match and config
    logic [CW-1:0]         r_hrs, r_hre, r_hqs, r_hqe;
    logic                  r_held_valid;
    logic [COORD_BITS-1:0] r_min_len;

    // incoming match after masking
    logic [CW-1:0]  nrs, nre, nqs, nqe;
    t_decision      dec;
    logic           accept, space;
    logic           push_a, push_b;
    t_result        res_a, res_b;
    logic           n_held_valid;

    assign nrs = i_req.ref_start[CW-1:0];
    assign nre = i_req.ref_end[CW-1:0];
    assign nqs = i_req.qry_start[CW-1:0];
    assign nqe = i_req.qry_end[CW-1:0];

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;

    opf_decide #(
        .CW (CW)
    ) u_decide (
        .i_held_valid (r_held_valid),
        .i_hrs        (r_hrs),
        .i_hre        (r_hre),
        .i_hqs        (r_hqs),
        .i_hqe        (r_hqe),
        .i_nrs        (nrs),
        .i_nre        (nre),
        .i_nqs        (nqs),
        .i_nqe        (nqe),
        .i_min_len    (r_min_len),
        .o_dec        (dec)
    );

    // first result: the old held match, pushed out when the new one meets no pruning rule
    assign push_a          = accept && dec.emit_held;
    assign res_a.ref_start = COORD_BITS'(r_hrs);
    assign res_a.ref_end   = COORD_BITS'(r_hre);
    assign res_a.qry_start = COORD_BITS'(r_hqs);
    assign res_a.qry_end   = COORD_BITS'(r_hqe);
    assign res_a.last      = 1'b0;

    // second result: flush of whatever is held after this request
    assign push_b          = accept && i_req.list_end;
    assign res_b.ref_start = COORD_BITS'(dec.take_new ? nrs : r_hrs);
    assign res_b.ref_end   = COORD_BITS'(dec.take_new ? nre : r_hre);
    assign res_b.qry_start = COORD_BITS'(dec.take_new ? nqs : r_hqs);
    assign res_b.qry_end   = COORD_BITS'(dec.take_new ? nqe : r_hqe);
    assign res_b.last      = 1'b1;

    // list end leaves nothing held, so the next match opens a new list
    assign n_held_valid = accept ? !i_req.list_end : r_held_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_min_len    <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            if (i_cfg_we) begin
                r_min_len <= i_cfg_wdata;
            end
        end
    end

    // held coordinates: meaningful only while r_held_valid is set
    always_ff @(posedge i_clk) begin
        if (accept && dec.take_new) begin
            r_hrs <= nrs;
            r_hre <= nre;
            r_hqs <= nqs;
            r_hqe <= nqe;
        end
    end

    opf_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_data_a (res_a),
        .i_push_b (push_b),
        .i_data_b (res_b),
        .o_space  (space),
        .o_res    (o_res)
    );

endmodule

// File: src/overlap_pruning_filter_chk.sv
// port-level checker of the overlap pruning filter and its bind
`timescale 1ns / 1ps

`include "overlap_pruning_filter_assert.svh"

module overlap_pruning_filter_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_list_end,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [opf_pkg::COORD_BITS-1:0] i_out_ref_start,
    input logic                           i_out_last
);
    import opf_pkg::*;

    // nothing comes out right after reset
    `OPF_ASSERT_NXT_RST(a_quiet_after_reset, !i_rst_n, !i_out_valid)

    // a list end always leaves a flushed result waiting next cycle
    `OPF_ASSERT_NXT(a_flush_shows, i_in_valid && i_in_ready && i_in_list_end, i_out_valid)

    // back-pressure only comes from pending results
    `OPF_ASSERT_IMP(a_stall_has_cause, !i_in_ready, i_out_valid)

    // a stalled result holds
    `OPF_ASSERT_NXT(a_res_hold, i_out_valid && !i_out_ready,
                    i_out_valid && $stable(i_out_ref_start) && $stable(i_out_last))

endmodule

bind overlap_pruning_filter overlap_pruning_filter_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_in_list_end   (i_req.list_end),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_ref_start (o_res.out_ref_start),
    .i_out_last      (o_res.out_last)
);
